// ===== hw/rtl/ipv4_prefix_trie_lookup_unit_defines.svh =====
// Assertion macros for the prefix trie lookup unit
`ifndef IPV4_PREFIX_TRIE_LOOKUP_UNIT_DEFINES_SVH
`define IPV4_PREFIX_TRIE_LOOKUP_UNIT_DEFINES_SVH

// a implies b at the same edge
`define PTL_ASSERT_IMPL(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("ptl check failed");

// a implies b at the next edge
`define PTL_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("ptl check failed");

`endif

// ===== hw/rtl/ptl_pkg.sv =====
`default_nettype none
package ptl_pkg;
  localparam int unsigned MaxNodes  = 1024;
  localparam int unsigned NodeW     = $clog2(MaxNodes);
  localparam int unsigned AddrBits  = 32;
  localparam int unsigned LvlW      = $clog2(AddrBits + 1);
  localparam int unsigned CountBits = 16;
  localparam int unsigned TotW      = NodeW + 1;

  localparam logic [7:0] LabelEmpty = 8'h3F;
  localparam logic [7:0] LabelNone  = 8'h20;
  localparam logic [CountBits-1:0] CountMax = '1;

  localparam logic [1:0] ModeAdd  = 2'd0;
  localparam logic [1:0] ModeRem  = 2'd1;
  localparam logic [1:0] ModeFind = 2'd2;

  localparam logic [1:0] StatOk   = 2'd0;
  localparam logic [1:0] StatMiss = 2'd1;
  localparam logic [1:0] StatFull = 2'd2;

  // one node word: zero child, one child, pass count, mark, label
  typedef struct packed {
    logic [NodeW-1:0]     c0;
    logic [NodeW-1:0]     c1;
    logic [CountBits-1:0] cnt;
    logic                 mark;
    logic [7:0]           label;
  } node_t;

  localparam int unsigned InW  = 2 + AddrBits + LvlW + 8;
  localparam int unsigned InTW = ((InW + 7) / 8) * 8;
  localparam int unsigned OutW = 2 + 1 + 8 + LvlW + LvlW + TotW;
  localparam int unsigned OutTW = ((OutW + 7) / 8) * 8;
endpackage
`default_nettype wire

// ===== hw/rtl/ipv4_prefix_trie_lookup_unit.sv =====
// Channel | Dir | tdata fields (low bit up)
// s_axis  | in  | mode[1:0] address[33:2] prefix_len[39:34] prefix_name[47:40]
// m_axis  | out | status[1:0] match_found[2] match_name[10:3] match_depth[16:11]
//         |     |   tree_depth[22:17] node_total[33:23]
// One transaction at a time. After reset a clearing pass over all MaxNodes entries
// initializes node memory and free list before s_axis_tready first rises.
// Each trie level visited passes through read issue, read wait and process states;
// add walks twice (probe, then build) plus a fill step per new node, remove walks
// twice plus a prune step for the first pruned node and a read, wait, process and
// prune sequence for each further one, find walks once; a sweep of the 32 level
// counters gives the tree depth.
// Reset is asynchronous active low; the result register holds until taken,
// and s_axis_tready stays low from acceptance until the result is taken.
`default_nettype none
module ipv4_prefix_trie_lookup_unit import ptl_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  // mode, address, prefix_len, prefix_name
  input  wire logic [InTW-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  // status, match_found, match_name, match_depth, tree_depth, node_total
  output logic [OutTW-1:0]      m_axis_tdata
);

  typedef enum logic [3:0] {
    StInit, StIdle, StRd, StWait, StProc, StFill, StPrune,
    StFinish, StSweep, StOut
  } state_e;

  // node memory and free-list stack
  node_t             mem [MaxNodes];
  logic [NodeW-1:0]  fl  [MaxNodes];
  // node count per level below the root
  logic [TotW-1:0]   lvl_cnt_q [1:AddrBits];

  state_e            state_q;
  logic [NodeW:0]    init_q;
  logic [1:0]        mode_q;
  logic [AddrBits-1:0] addr_q;
  logic [LvlW-1:0]   len_q;
  logic [7:0]        name_q;
  logic [1:0]        pass_q;       // 0 probe, 1 build/modify, 2 prune
  logic [LvlW-1:0]   d_q;
  logic [NodeW-1:0]  cur_q, par_q;
  logic              pbit_q;
  node_t             par_nd_q;     // parent word as last written
  logic [TotW-1:0]   fcnt_q;
  logic [1:0]        stat_q;
  logic              found_q;
  logic [7:0]        mname_q;
  logic [LvlW-1:0]   mdepth_q, tdepth_q, sw_q;
  logic [OutTW-1:0]  out_q;
  node_t             rd_q;
  logic [NodeW-1:0]  fl_rd_q;

  logic              we, fl_we;
  logic [NodeW-1:0]  waddr, raddr, fl_waddr, fl_raddr;
  node_t             wdata;
  logic [NodeW-1:0]  fl_wdata;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
    if (fl_we) fl[fl_waddr] <= fl_wdata;
    fl_rd_q <= fl[fl_raddr];
  end

  logic [LvlW-1:0] len_in;
  logic [LvlW-1:0] len_raw;
  assign len_raw = s_axis_tdata[2+AddrBits +: LvlW];
  assign len_in  = (len_raw > LvlW'(AddrBits)) ? LvlW'(AddrBits) : len_raw;

  logic abit;
  logic [NodeW-1:0] child;
  logic [4:0] bidx;
  assign bidx  = 5'(AddrBits - 1 - int'(d_q));
  assign abit  = addr_q[bidx];
  assign child = abit ? rd_q.c1 : rd_q.c0;

  node_t nd;
  logic  is_cnt_max;
  assign is_cnt_max = (rd_q.cnt == CountMax);

  always_comb begin
    we = 1'b0; waddr = cur_q; wdata = rd_q;
    fl_we = 1'b0; fl_waddr = fcnt_q[NodeW-1:0]; fl_wdata = cur_q;
    raddr = cur_q; fl_raddr = fcnt_q[NodeW-1:0] - NodeW'(1);
    nd = rd_q;
    unique case (state_q)
      StInit: begin
        we = 1'b1; waddr = init_q[NodeW-1:0];
        wdata = '{c0: '0, c1: '0, cnt: '0, mark: 1'b0, label: LabelEmpty};
        fl_we = 1'b1; fl_waddr = init_q[NodeW-1:0];
        fl_wdata = init_q[NodeW-1:0] + NodeW'(1);
      end
      StProc: begin
        if (pass_q == 2'd1 && mode_q == ModeAdd) begin
          // raise count unless root or at CountMax, link a new child or mark the end node
          if (d_q != '0 && !is_cnt_max) nd.cnt = rd_q.cnt + 1'b1;
          if (d_q == len_q) begin
            nd.mark = 1'b1; nd.label = name_q;
          end else if (child == '0) begin
            if (abit) nd.c1 = fl_rd_q; else nd.c0 = fl_rd_q;
          end
          we = 1'b1; wdata = nd;
        end else if (pass_q == 2'd1 && mode_q == ModeRem) begin
          if (d_q != '0 && !is_cnt_max) nd.cnt = rd_q.cnt - 1'b1;
          we = 1'b1;
          if (d_q != '0 && nd.cnt == '0) begin
            // unlink this chain from its parent
            waddr = par_q; wdata = par_nd_q;
            if (pbit_q) wdata.c1 = '0; else wdata.c0 = '0;
          end else begin
            if (d_q == len_q) begin
              nd.mark = 1'b0; nd.label = LabelEmpty;
            end
            wdata = nd;
          end
        end
      end
      StFill: begin
        // new node, its count is raised when the walk reaches it
        we = 1'b1; waddr = fl_rd_q;
        wdata = '{c0: '0, c1: '0, cnt: '0, mark: 1'b0, label: LabelEmpty};
      end
      StPrune: begin
        we = 1'b1; waddr = cur_q;
        wdata = '{c0: '0, c1: '0, cnt: '0, mark: 1'b0, label: LabelEmpty};
        fl_we = 1'b1; fl_waddr = fcnt_q[NodeW-1:0]; fl_wdata = cur_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StInit; init_q <= '0; fcnt_q <= TotW'(MaxNodes - 1);
      m_axis_tvalid <= 1'b0; s_axis_tready <= 1'b0;
      for (int i = 1; i <= AddrBits; i++) lvl_cnt_q[i] <= '0;
    end else begin
      unique case (state_q)
        StInit: begin
          init_q <= init_q + 1'b1;
          if (init_q == (NodeW+1)'(MaxNodes - 1)) begin
            state_q <= StIdle; s_axis_tready <= 1'b1;
          end
        end
        StIdle: if (s_axis_tvalid) begin
          s_axis_tready <= 1'b0;
          mode_q <= s_axis_tdata[1:0];
          addr_q <= s_axis_tdata[2 +: AddrBits];
          len_q  <= len_in;
          name_q <= s_axis_tdata[2+AddrBits+LvlW +: 8];
          pass_q <= '0; d_q <= '0; cur_q <= '0;
          stat_q <= StatOk; found_q <= 1'b0; mname_q <= LabelNone;
          mdepth_q <= '0;
          state_q <= (s_axis_tdata[1:0] inside {ModeAdd, ModeRem, ModeFind}) ?
                     StRd : StFinish;
        end
        StRd: state_q <= StWait;
        StWait: state_q <= StProc;
        StProc: begin
          state_q <= StRd;
          unique case (mode_q)
            ModeFind: begin
              if (rd_q.mark) begin
                found_q <= 1'b1; mname_q <= rd_q.label; mdepth_q <= d_q;
              end
              if (d_q == LvlW'(AddrBits) || child == '0) state_q <= StFinish;
              else begin cur_q <= child; d_q <= d_q + 1'b1; end
            end
            ModeAdd: begin
              if (pass_q == 2'd0) begin
                if (d_q < len_q && child != '0) begin
                  cur_q <= child; d_q <= d_q + 1'b1;
                end else if (TotW'(len_q - d_q) > fcnt_q) begin
                  stat_q <= StatFull; state_q <= StFinish;
                end else begin
                  pass_q <= 2'd1; cur_q <= '0; d_q <= '0;
                end
              end else begin
                // node word written back from nd this cycle
                if (d_q == len_q) state_q <= StFinish;
                else if (child == '0) state_q <= StFill;
                else begin
                  cur_q <= child; d_q <= d_q + 1'b1;
                end
              end
            end
            ModeRem: begin
              if (pass_q == 2'd0) begin
                if (d_q < len_q) begin
                  if (child == '0) begin stat_q <= StatMiss; state_q <= StFinish; end
                  else begin cur_q <= child; d_q <= d_q + 1'b1; end
                end else if (!rd_q.mark || rd_q.label != name_q) begin
                  stat_q <= StatMiss; state_q <= StFinish;
                end else begin
                  pass_q <= 2'd1; cur_q <= '0; d_q <= '0;
                end
              end else if (pass_q == 2'd2) begin
                state_q <= StPrune;
              end else begin
                if (d_q != '0 && nd.cnt == '0) begin
                  // parent unlinked this cycle, free the chain from here
                  pass_q <= 2'd2; state_q <= StPrune;
                end else if (d_q == len_q) begin
                  state_q <= StFinish;
                end else begin
                  par_q <= cur_q; pbit_q <= abit; par_nd_q <= nd;
                  cur_q <= child; d_q <= d_q + 1'b1;
                end
              end
            end
            default: state_q <= StFinish;
          endcase
        end
        StFill: begin
          fcnt_q <= fcnt_q - 1'b1;
          lvl_cnt_q[d_q + 1'b1] <= lvl_cnt_q[d_q + 1'b1] + 1'b1;
          cur_q <= fl_rd_q; d_q <= d_q + 1'b1; state_q <= StRd;
        end
        StPrune: begin
          fcnt_q <= fcnt_q + 1'b1;
          if (lvl_cnt_q[d_q] != '0) lvl_cnt_q[d_q] <= lvl_cnt_q[d_q] - 1'b1;
          if (d_q < len_q && child != '0) begin
            cur_q <= child; d_q <= d_q + 1'b1; state_q <= StRd;
          end else state_q <= StFinish;
        end
        StFinish: begin sw_q <= LvlW'(1); tdepth_q <= '0; state_q <= StSweep; end
        StSweep: begin
          if (lvl_cnt_q[sw_q] != '0) tdepth_q <= sw_q;
          if (sw_q == LvlW'(AddrBits)) state_q <= StOut;
          else sw_q <= sw_q + 1'b1;
        end
        StOut: begin
          if (!m_axis_tvalid) begin
            m_axis_tvalid <= 1'b1;
            out_q <= OutTW'({TotW'(TotW'(MaxNodes) - fcnt_q), tdepth_q,
                     (mode_q == ModeFind) ? mdepth_q : LvlW'(0),
                     (mode_q == ModeFind) ? mname_q : 8'd0,
                     (mode_q == ModeFind) & found_q, stat_q});
          end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0; s_axis_tready <= 1'b1; state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign m_axis_tdata = out_q;

endmodule
`default_nettype wire

// ===== hw/rtl/ptl_checker.sv =====
`default_nettype none
`include "ipv4_prefix_trie_lookup_unit_defines.svh"
module ptl_checker import ptl_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             s_axis_tvalid,
  input wire logic             s_axis_tready,
  input wire logic             m_axis_tvalid,
  input wire logic             m_axis_tready,
  input wire logic [OutTW-1:0] m_axis_tdata
);
  `PTL_ASSERT_IMPL(a_one_at_a_time, clk_i, rst_ni, m_axis_tvalid, !s_axis_tready)
  `PTL_ASSERT_NEXT(a_take_then_busy, clk_i, rst_ni, s_axis_tvalid && s_axis_tready,
    !s_axis_tready)
  `PTL_ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata))
endmodule

bind ipv4_prefix_trie_lookup_unit ptl_checker u_ptl_checker (.*);
`default_nettype wire
